/* rtl/core/ght_pkg.sv */
// shared types, codes and helpers of the generational handle table
package ght_pkg;

    // request modes
    localparam logic [2:0] MODE_INSERT       = 3'd0;
    localparam logic [2:0] MODE_LOOKUP       = 3'd1;
    localparam logic [2:0] MODE_CLOSE_KIND   = 3'd2;
    localparam logic [2:0] MODE_CLOSE_STORED = 3'd3;
    localparam logic [2:0] MODE_ALIVE        = 3'd4;
    localparam logic [2:0] MODE_DISPOSE      = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_ARG  = 3'd1;
    localparam logic [2:0] ST_CLOSED   = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_STALE    = 3'd4;
    localparam logic [2:0] ST_WRONG    = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;
    localparam logic [2:0] ST_OVERFLOW = 3'd7;

    // register indexes, taken from paddr[2]
    localparam logic CFG_IDX_SLOTS      = 1'b0;
    localparam logic CFG_IDX_KIND_LIMIT = 1'b1;

    localparam logic [5:0] CFG_SLOTS_RST      = 6'd32;
    localparam logic [4:0] CFG_KIND_LIMIT_RST = 5'd10;

    // kind used by close stored kind when the stored kind is not valid
    localparam logic [3:0] KIND_FALLBACK = 4'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] slot;
        logic [31:0] generation;
        logic [3:0]  kind;
        logic [63:0] payload;
        logic        has_cleanup;
        logic [63:0] cleanup_tag;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_out;
        logic [31:0] generation_out;
        logic [63:0] payload_out;
        logic        alive;
        logic        cleanup_fire;
        logic [63:0] cleanup_tag_out;
        logic [5:0]  live_count;
        logic        last;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic count;
        logic dscan;
        logic dread;
        logic dempty;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_dispose;
        logic any_live;
        logic rsp_last;
    } t_sts;

    function automatic logic kind_ok(input logic [3:0] k, input logic [4:0] lim);
        return (k != 4'd0) && ({1'b0, k} < lim);
    endfunction

endpackage

/* rtl/core/ght_ram.sv */
// generic single write port, single read port ram with registered read
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ght_ctrl.sv */
// sequencer of the handle table: request, count, dispose walk and result handshake
module ght_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    input  ght_pkg::t_sts i_sts,
    output ght_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COUNT,
        S_DSCAN,
        S_DREAD,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_req_ready;
    logic   r_rsp_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.req_dispose ? S_DSCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_COUNT;
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = S_OUT;
            end
            S_DSCAN: begin
                if (i_sts.any_live) begin
                    o_cmd.dscan = 1'b1;
                    n_state     = S_DREAD;
                end else begin
                    // no event left: first pass gives one empty result
                    o_cmd.dempty = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_DREAD: begin
                o_cmd.dread = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_rsp_ready) begin
                    n_state = i_sts.rsp_last ? S_IDLE : S_DSCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req_ready <= 1'b1;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req_ready <= (n_state == S_IDLE);
            r_rsp_valid <= (n_state == S_OUT);
        end
    end

    assign o_req_ready = r_req_ready;
    assign o_rsp_valid = r_rsp_valid;

endmodule

/* rtl/core/ght_datapath.sv */
// slot state, id checks, slot memories and result register of the handle table
module ght_datapath #(
    parameter int SLOTS    = 32,
    parameter int GEN_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [5:0]    i_cfg_slots,
    input  logic [4:0]    i_cfg_kind_limit,
    input  ght_pkg::t_req i_req,
    input  ght_pkg::t_cmd i_cmd,
    output ght_pkg::t_sts o_sts,
    output ght_pkg::t_rsp o_rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [GEN_BITS-1:0] GEN_MAX = '1;
    localparam logic [GEN_BITS-1:0] GEN_ONE = GEN_BITS'(1);
    localparam logic [5:0] SLOTS_6 = 6'(SLOTS);

    logic [SLOTS-1:0] r_live;
    logic [SLOTS-1:0] r_want;
    logic [SLOTS-1:0] r_gen_vld;
    logic [3:0]       r_kind [SLOTS];
    logic             r_disposed;
    logic [5:0]       r_dcap;
    ght_pkg::t_req    r_req;
    logic [IW-1:0]    r_idx;
    logic             r_found;
    ght_pkg::t_rsp    r_rsp;

    logic [5:0]          cap;
    logic [SLOTS-1:0]    cap_mask;
    logic [SLOTS-1:0]    dcap_mask;
    logic [SLOTS-1:0]    free_vec;
    logic [SLOTS-1:0]    dlive_vec;
    logic [SLOTS-1:0]    cur_onehot;
    logic [IW-1:0]       free_idx;
    logic [IW-1:0]       live_idx;
    logic [IW-1:0]       slot_idx;
    logic [IW-1:0]       rd_addr;
    logic [5:0]          live_cnt;

    logic [GEN_BITS-1:0] gen_rdata;
    logic [127:0]        pay_rdata;
    logic [GEN_BITS-1:0] gen_cur;
    logic [63:0]         cur_payload;
    logic [63:0]         cur_token;
    logic [3:0]          stored_kind;
    logic                cur_live;
    logic                cur_want;
    logic [3:0]          eff_kind;
    logic                id_zero;
    logic                id_oor;
    logic [2:0]          id_status;
    logic [2:0]          ex_status;
    logic                is_close;
    logic                insert_ok;
    logic                close_ok;
    logic                gen_we;
    logic                pay_we;
    logic                clear_cur;

    // capacity now, and the walk limit latched when dispose starts
    always_comb begin
        if (r_disposed) begin
            cap = 6'd0;
        end else if (i_cfg_slots < SLOTS_6) begin
            cap = i_cfg_slots;
        end else begin
            cap = SLOTS_6;
        end
        for (int i = 0; i < SLOTS; i++) begin
            cap_mask[i]   = (6'(i) < cap);
            dcap_mask[i]  = (6'(i) < r_dcap);
            cur_onehot[i] = (IW'(i) == r_idx);
        end
        free_vec  = ~r_live & cap_mask;
        dlive_vec = r_live & dcap_mask;
    end

    // lowest free slot and lowest live slot of the dispose walk
    always_comb begin
        free_idx = '0;
        live_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_idx = IW'(i);
            end
            if (dlive_vec[i]) begin
                live_idx = IW'(i);
            end
        end
    end

    always_comb begin
        live_cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
            live_cnt = live_cnt + 6'(r_live[i] & cap_mask[i]);
        end
    end

    assign slot_idx = IW'(i_req.slot - 32'd1);
    assign rd_addr  = i_cmd.dscan ? live_idx :
                      ((i_req.mode == ght_pkg::MODE_INSERT) ? free_idx : slot_idx);

    // slot read data and checks
    always_comb begin
        gen_cur     = r_gen_vld[r_idx] ? gen_rdata : GEN_ONE;
        cur_payload = pay_rdata[127:64];
        cur_token   = pay_rdata[63:0];
        stored_kind = r_kind[r_idx];
        cur_live    = r_live[r_idx];
        cur_want    = r_want[r_idx];
        is_close    = (r_req.mode == ght_pkg::MODE_CLOSE_KIND) ||
                      (r_req.mode == ght_pkg::MODE_CLOSE_STORED);

        if (r_req.mode == ght_pkg::MODE_CLOSE_STORED) begin
            eff_kind = ght_pkg::kind_ok(stored_kind, i_cfg_kind_limit) ? stored_kind
                                                                     : ght_pkg::KIND_FALLBACK;
        end else begin
            eff_kind = r_req.kind;
        end

        id_zero = (r_req.slot == 32'd0) || (r_req.generation == 32'd0);
        id_oor  = (r_req.slot > {26'd0, cap});
        priority if (id_zero) begin
            id_status = ght_pkg::ST_BAD_ARG;
        end else if (id_oor) begin
            id_status = ght_pkg::ST_RANGE;
        end else if (32'(gen_cur) != r_req.generation) begin
            id_status = ght_pkg::ST_STALE;
        end else if (!cur_live) begin
            id_status = ght_pkg::ST_CLOSED;
        end else begin
            id_status = ght_pkg::ST_OK;
        end

        unique case (r_req.mode)
            ght_pkg::MODE_INSERT: begin
                if (!ght_pkg::kind_ok(r_req.kind, i_cfg_kind_limit) ||
                    (r_req.payload == 64'd0)) begin
                    ex_status = ght_pkg::ST_BAD_ARG;
                end else if (!r_found) begin
                    ex_status = ght_pkg::ST_FULL;
                end else begin
                    ex_status = ght_pkg::ST_OK;
                end
            end
            ght_pkg::MODE_LOOKUP: begin
                if (!ght_pkg::kind_ok(r_req.kind, i_cfg_kind_limit)) begin
                    ex_status = ght_pkg::ST_BAD_ARG;
                end else if (id_status != ght_pkg::ST_OK) begin
                    ex_status = id_status;
                end else if (stored_kind != r_req.kind) begin
                    ex_status = ght_pkg::ST_WRONG;
                end else begin
                    ex_status = ght_pkg::ST_OK;
                end
            end
            ght_pkg::MODE_CLOSE_KIND, ght_pkg::MODE_CLOSE_STORED: begin
                // stored-kind close screens the id before picking its kind
                priority if ((r_req.mode == ght_pkg::MODE_CLOSE_STORED) && id_zero) begin
                    ex_status = ght_pkg::ST_BAD_ARG;
                end else if ((r_req.mode == ght_pkg::MODE_CLOSE_STORED) && id_oor) begin
                    ex_status = ght_pkg::ST_RANGE;
                end else if (!ght_pkg::kind_ok(eff_kind, i_cfg_kind_limit)) begin
                    ex_status = ght_pkg::ST_BAD_ARG;
                end else if (id_status != ght_pkg::ST_OK) begin
                    ex_status = id_status;
                end else if (stored_kind != eff_kind) begin
                    ex_status = ght_pkg::ST_WRONG;
                end else if (gen_cur == GEN_MAX) begin
                    ex_status = ght_pkg::ST_OVERFLOW;
                end else begin
                    ex_status = ght_pkg::ST_OK;
                end
            end
            ght_pkg::MODE_ALIVE: ex_status = id_status;
            default:             ex_status = ght_pkg::ST_BAD_ARG;
        endcase

        insert_ok = i_cmd.exec && (r_req.mode == ght_pkg::MODE_INSERT) &&
                    (ex_status == ght_pkg::ST_OK);
        close_ok  = i_cmd.exec && is_close && (ex_status == ght_pkg::ST_OK);
        clear_cur = close_ok || i_cmd.dread;
        gen_we    = close_ok || (i_cmd.dread && (gen_cur != GEN_MAX));
        pay_we    = insert_ok;
    end

    ght_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (r_idx),
        .i_wdata (gen_cur + GEN_ONE),
        .i_re    (i_cmd.accept | i_cmd.dscan),
        .i_raddr (rd_addr),
        .o_rdata (gen_rdata)
    );

    ght_ram #(
        .WIDTH (128),
        .DEPTH (SLOTS)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (r_idx),
        .i_wdata ({r_req.payload, r_req.cleanup_tag}),
        .i_re    (i_cmd.accept | i_cmd.dscan),
        .i_raddr (rd_addr),
        .o_rdata (pay_rdata)
    );

    // slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_want     <= '0;
            r_gen_vld  <= '0;
            r_disposed <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_kind[i] <= 4'd0;
            end
        end else begin
            if (i_cmd.accept && (i_req.mode == ght_pkg::MODE_DISPOSE)) begin
                r_disposed <= 1'b1;
            end
            if (insert_ok) begin
                r_live[r_idx] <= 1'b1;
                r_want[r_idx] <= r_req.has_cleanup;
                r_kind[r_idx] <= r_req.kind;
            end
            if (clear_cur) begin
                r_live[r_idx] <= 1'b0;
                r_want[r_idx] <= 1'b0;
                r_kind[r_idx] <= 4'd0;
            end
            if (gen_we) begin
                r_gen_vld[r_idx] <= 1'b1;
            end
        end
    end

    // request capture, slot index and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_req;
            r_idx   <= rd_addr;
            r_found <= |free_vec;
            r_dcap  <= cap;
        end
        if (i_cmd.dscan) begin
            r_idx <= live_idx;
        end
        if (i_cmd.exec) begin
            r_rsp                 <= '0;
            r_rsp.status          <= ex_status;
            r_rsp.last            <= 1'b1;
            if (insert_ok) begin
                r_rsp.slot_out       <= 6'(r_idx) + 6'd1;
                r_rsp.generation_out <= 32'(gen_cur);
            end
            if (close_ok || ((r_req.mode == ght_pkg::MODE_LOOKUP) &&
                             (ex_status == ght_pkg::ST_OK))) begin
                r_rsp.payload_out <= cur_payload;
            end
            if (close_ok && cur_want) begin
                r_rsp.cleanup_fire    <= 1'b1;
                r_rsp.cleanup_tag_out <= cur_token;
            end
            r_rsp.alive <= (r_req.mode == ght_pkg::MODE_ALIVE) &&
                           (ex_status == ght_pkg::ST_OK);
        end
        if (i_cmd.count) begin
            r_rsp.live_count <= live_cnt;
        end
        if (i_cmd.dread) begin
            r_rsp                 <= '0;
            r_rsp.status          <= (gen_cur == GEN_MAX) ? ght_pkg::ST_OVERFLOW
                                                          : ght_pkg::ST_OK;
            r_rsp.payload_out     <= cur_payload;
            r_rsp.cleanup_fire    <= cur_want;
            r_rsp.cleanup_tag_out <= cur_want ? cur_token : 64'd0;
            // last event when no other live slot remains below the walk limit
            r_rsp.last            <= ~|(dlive_vec & ~cur_onehot);
        end
        if (i_cmd.dempty) begin
            r_rsp      <= '0;
            r_rsp.last <= 1'b1;
        end
    end

    assign o_sts.req_dispose = (i_req.mode == ght_pkg::MODE_DISPOSE);
    assign o_sts.any_live    = |dlive_vec;
    assign o_sts.rsp_last    = r_rsp.last;
    assign o_rsp             = r_rsp;

endmodule

/* rtl/core/generational_handle_table_core.sv */
// Generational handle table: lookup, insert, close, alive check and dispose of slot handles.
// A request is accepted, passes the exec and count states, and its result is then held valid;
// the next request is taken the cycle after the result transfer, not before.
// Dispose walks each live slot below capacity through scan, slot read and result states;
// with no live slot it gives one result.
// Reset (synchronous, active low): all slots free at generation 1, registers to defaults.
module generational_handle_table_core #(
    parameter int SLOTS    = 32,
    parameter int GEN_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,

    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ght_pkg::t_req i_req,

    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ght_pkg::t_rsp o_rsp,

    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [5:0]    r_slots_in_use;
    logic [4:0]    r_kind_limit;
    ght_pkg::t_cmd cmd;
    ght_pkg::t_sts sts;

    // register file, written on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= ght_pkg::CFG_SLOTS_RST;
            r_kind_limit   <= ght_pkg::CFG_KIND_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                ght_pkg::CFG_IDX_SLOTS:      r_slots_in_use <= pwdata[5:0];
                ght_pkg::CFG_IDX_KIND_LIMIT: r_kind_limit   <= pwdata[4:0];
                default:                     r_slots_in_use <= r_slots_in_use;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ght_pkg::CFG_IDX_SLOTS:      prdata = {26'd0, r_slots_in_use};
            ght_pkg::CFG_IDX_KIND_LIMIT: prdata = {27'd0, r_kind_limit};
            default:                     prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    ght_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ght_datapath #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_slots      (r_slots_in_use),
        .i_cfg_kind_limit (r_kind_limit),
        .i_req            (i_req),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_rsp            (o_rsp)
    );

endmodule

/* test/generational_handle_table_core_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the generational handle table core with a built-in slot table model
module generational_handle_table_core_tb;
    import ght_pkg::*;

    localparam int          SLOT_COUNT  = 32;
    localparam logic [31:0] GEN_LIMIT   = 32'hFFFF_FFFF;
    localparam int          MAX_IDLE    = 17;
    localparam int          CYCLE_LIMIT = 250000;
    // modes the block does not define
    localparam logic [2:0]  MODE_SPARE_A = 3'd6;
    localparam logic [2:0]  MODE_SPARE_B = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    t_req        req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b1;
    t_rsp        rsp;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    generational_handle_table_core #(
        .SLOTS    (SLOT_COUNT),
        .GEN_BITS (32)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // slot table as the block should hold it
    logic [31:0] tab_gen     [SLOT_COUNT];
    logic        tab_live    [SLOT_COUNT];
    logic [3:0]  tab_kind    [SLOT_COUNT];
    logic [63:0] tab_payload [SLOT_COUNT];
    logic        tab_wants   [SLOT_COUNT];
    logic [63:0] tab_token   [SLOT_COUNT];
    logic        tab_disposed;
    logic [5:0]  cfg_slots;
    logic [4:0]  cfg_kind_limit;

    t_rsp        awaited_results[$];
    int          error_count   = 0;
    int          req_count     = 0;
    int          rsp_count     = 0;
    int          setting_count = 0;
    int          dispose_events = 0;
    int unsigned cycle_count   = 0;
    int unsigned next_gap      = 1;
    int unsigned rsp_hold      = 0;
    bit          full_rate     = 1'b0;

    function automatic void free_entry(input int unsigned ix);
        tab_live[ix]    = 1'b0;
        tab_kind[ix]    = '0;
        tab_payload[ix] = '0;
        tab_wants[ix]   = 1'b0;
        tab_token[ix]   = '0;
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tab_gen[i] = 32'd1;
            free_entry(i);
        end
        tab_disposed   = 1'b0;
        cfg_slots      = CFG_SLOTS_RST;
        cfg_kind_limit = CFG_KIND_LIMIT_RST;
    endfunction

    function automatic int unsigned table_capacity();
        if (tab_disposed)
            return 0;
        return (cfg_slots < SLOT_COUNT) ? cfg_slots : SLOT_COUNT;
    endfunction

    function automatic logic kind_valid(input logic [3:0] k);
        return (k != 4'd0) && ({1'b0, k} < cfg_kind_limit);
    endfunction

    function automatic logic [2:0] id_status(input logic [31:0] slot, input logic [31:0] gen);
        if (slot == 0 || gen == 0)
            return ST_BAD_ARG;
        if (slot > table_capacity())
            return ST_RANGE;
        if (tab_gen[slot - 1] != gen)
            return ST_STALE;
        if (!tab_live[slot - 1])
            return ST_CLOSED;
        return ST_OK;
    endfunction

    function automatic void fill_event(inout t_rsp r, input int unsigned ix);
        r.payload_out     = tab_payload[ix];
        r.cleanup_fire    = tab_wants[ix];
        r.cleanup_tag_out = tab_wants[ix] ? tab_token[ix] : '0;
    endfunction

    function automatic logic [2:0] close_entry(input logic [31:0] slot, input logic [31:0] gen,
                                               input logic [3:0] kind, inout t_rsp r);
        logic [2:0]  st;
        int unsigned ix;
        if (!kind_valid(kind))
            return ST_BAD_ARG;
        st = id_status(slot, gen);
        if (st != ST_OK)
            return st;
        ix = slot - 1;
        if (tab_kind[ix] != kind)
            return ST_WRONG;
        if (tab_gen[ix] >= GEN_LIMIT)
            return ST_OVERFLOW;
        fill_event(r, ix);
        free_entry(ix);
        tab_gen[ix] = tab_gen[ix] + 1;
        return ST_OK;
    endfunction

    // applies one request to the table and queues the results it must give
    function automatic void predict_table_op(input t_req r);
        t_rsp        step_results[$];
        t_rsp        one;
        logic [2:0]  st;
        logic [3:0]  stored_kind;
        int unsigned cap;
        int unsigned live_now;
        cap = table_capacity();
        one = '0;
        case (r.mode)
            MODE_INSERT: begin
                if (!kind_valid(r.kind) || r.payload == '0) begin
                    one.status = ST_BAD_ARG;
                end else begin
                    one.status = ST_FULL;
                    for (int i = 0; i < cap; i++) begin
                        if (!tab_live[i]) begin
                            tab_live[i]        = 1'b1;
                            tab_kind[i]        = r.kind;
                            tab_payload[i]     = r.payload;
                            tab_wants[i]       = r.has_cleanup;
                            tab_token[i]       = r.cleanup_tag;
                            one.status         = ST_OK;
                            one.slot_out       = i + 1;
                            one.generation_out = tab_gen[i];
                            break;
                        end
                    end
                end
                step_results.push_back(one);
            end
            MODE_LOOKUP: begin
                if (!kind_valid(r.kind)) begin
                    st = ST_BAD_ARG;
                end else begin
                    st = id_status(r.slot, r.generation);
                    if (st == ST_OK && tab_kind[r.slot - 1] != r.kind)
                        st = ST_WRONG;
                end
                one.status = st;
                if (st == ST_OK)
                    one.payload_out = tab_payload[r.slot - 1];
                step_results.push_back(one);
            end
            MODE_CLOSE_KIND: begin
                st = close_entry(r.slot, r.generation, r.kind, one);
                one.status = st;
                step_results.push_back(one);
            end
            MODE_CLOSE_STORED: begin
                if (r.slot == 0 || r.generation == 0) begin
                    st = ST_BAD_ARG;
                end else if (r.slot > cap) begin
                    st = ST_RANGE;
                end else begin
                    stored_kind = tab_kind[r.slot - 1];
                    if (!kind_valid(stored_kind))
                        stored_kind = KIND_FALLBACK;
                    st = close_entry(r.slot, r.generation, stored_kind, one);
                end
                one.status = st;
                step_results.push_back(one);
            end
            MODE_ALIVE: begin
                st = id_status(r.slot, r.generation);
                one.status = st;
                one.alive  = (st == ST_OK);
                step_results.push_back(one);
            end
            MODE_DISPOSE: begin
                for (int i = 0; i < cap; i++) begin
                    if (tab_live[i]) begin
                        one = '0;
                        fill_event(one, i);
                        free_entry(i);
                        // generation stays put at its limit, the slot is closed anyway
                        if (tab_gen[i] < GEN_LIMIT)
                            tab_gen[i] = tab_gen[i] + 1;
                        else
                            one.status = ST_OVERFLOW;
                        step_results.push_back(one);
                    end
                end
                dispose_events += step_results.size();
                tab_disposed = 1'b1;
                if (step_results.size() == 0)
                    step_results.push_back('0);
            end
            default: begin
                one.status = ST_BAD_ARG;
                step_results.push_back(one);
            end
        endcase

        cap = table_capacity();
        live_now = 0;
        for (int i = 0; i < cap; i++)
            if (tab_live[i])
                live_now++;
        for (int k = 0; k < step_results.size(); k++) begin
            step_results[k].live_count = live_now;
            step_results[k].last       = (k == step_results.size() - 1);
            awaited_results.push_back(step_results[k]);
        end
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            error_count++;
        end
    endtask

    // result side: check every transfer, then, except at full rate, stall ready for a random while
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                rsp_count++;
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h", $time, rsp);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, rsp.status);
                    compare_field("slot_out", want.slot_out, rsp.slot_out);
                    compare_field("generation_out", want.generation_out, rsp.generation_out);
                    compare_field("payload_out", want.payload_out, rsp.payload_out);
                    compare_field("alive", want.alive, rsp.alive);
                    compare_field("cleanup_fire", want.cleanup_fire, rsp.cleanup_fire);
                    compare_field("cleanup_tag_out", want.cleanup_tag_out, rsp.cleanup_tag_out);
                    compare_field("live_count", want.live_count, rsp.live_count);
                    compare_field("last", want.last, rsp.last);
                end
                rsp_hold = full_rate ? 0 : $urandom_range(0, MAX_IDLE);
                if (rsp_hold != 0)
                    rsp_ready <= 1'b0;
            end else if (rsp_hold != 0) begin
                rsp_hold--;
                if (rsp_hold == 0)
                    rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     awaited_results.size());
            $display("generational_handle_table_core test failed");
            $finish;
        end
    end

    // valid stays up across back-to-back requests, it only drops when a gap follows
    task automatic send_request(input t_req r);
        repeat (next_gap) @(posedge clk);
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        req_count++;
        predict_table_op(r);
        next_gap = full_rate ? 0 : $urandom_range(0, MAX_IDLE);
        if (next_gap != 0)
            req_valid <= 1'b0;
    endtask

    task automatic hold_requests();
        if (next_gap == 0) begin
            req_valid <= 1'b0;
            next_gap = 1;
        end
    endtask

    task automatic wait_until_idle();
        hold_requests();
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write transfer followed by a read-back of the same register
    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [31:0] stored;
        stored = (idx == CFG_IDX_SLOTS) ? (value & 32'h3F) : (value & 32'h1F);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == CFG_IDX_SLOTS)
            cfg_slots = value[5:0];
        else
            cfg_kind_limit = value[4:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== stored) begin
            $display("%0t ns: register %0d read-back, expected %0h, actual %0h", $time, idx,
                     stored, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_registers(input logic [5:0] slots, input logic [4:0] klimit);
        wait_until_idle();
        write_register(CFG_IDX_SLOTS, slots);
        write_register(CFG_IDX_KIND_LIMIT, klimit);
        setting_count++;
    endtask

    function automatic t_req make_req(input logic [2:0] mode, input logic [31:0] slot,
                                      input logic [31:0] gen, input logic [3:0] kind,
                                      input logic [63:0] payload, input logic wants,
                                      input logic [63:0] tag);
        t_req r;
        r.mode        = mode;
        r.slot        = slot;
        r.generation  = gen;
        r.kind        = kind;
        r.payload     = payload;
        r.has_cleanup = wants;
        r.cleanup_tag = tag;
        return r;
    endfunction

    // inserts, spare modes and id requests, mostly ids of live slots with their true generation and kind, some damaged
    function automatic t_req random_table_request();
        t_req        r;
        int unsigned roll;
        int unsigned start;
        int unsigned ix;
        int unsigned cap;
        bit          found;
        r.mode        = MODE_LOOKUP;
        r.slot        = $urandom;
        r.generation  = $urandom;
        r.kind        = $urandom_range(0, 15);
        r.payload     = {$urandom, $urandom};
        r.has_cleanup = $urandom_range(0, 1);
        r.cleanup_tag = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        cap  = table_capacity();
        if (roll < 30) begin
            r.mode = MODE_INSERT;
            if (cfg_kind_limit > 1 && $urandom_range(0, 9) != 0)
                r.kind = $urandom_range(1, cfg_kind_limit - 1);
            if ($urandom_range(0, 15) == 0)
                r.payload = '0;
        end else if (roll < 95) begin
            case (roll % 4)
                0: r.mode = MODE_LOOKUP;
                1: r.mode = MODE_CLOSE_KIND;
                2: r.mode = MODE_CLOSE_STORED;
                default: r.mode = MODE_ALIVE;
            endcase
            found = 1'b0;
            ix    = 0;
            start = $urandom_range(0, SLOT_COUNT - 1);
            for (int i = 0; i < SLOT_COUNT && !found; i++) begin
                ix = (start + i) % SLOT_COUNT;
                found = tab_live[ix];
            end
            if (found && $urandom_range(0, 9) < 7) begin
                r.slot       = ix + 1;
                r.generation = tab_gen[ix];
                r.kind       = tab_kind[ix];
            end else begin
                r.slot       = $urandom_range(0, SLOT_COUNT + 2);
                r.generation = (r.slot >= 1 && r.slot <= SLOT_COUNT) ? tab_gen[r.slot - 1] : 32'd1;
            end
            case ($urandom_range(0, 11))
                0: r.slot       = '0;
                1: r.generation = '0;
                2: r.generation = r.generation + 1;
                3: r.generation = r.generation - 1;
                4: r.slot       = cap + 1;
                5: r.kind       = $urandom_range(0, 15);
                6: begin
                    r.slot       = $urandom;
                    r.generation = $urandom;
                end
                default: ;
            endcase
        end else begin
            r.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        end
        return r;
    endfunction

    task automatic run_random_phase(input logic [5:0] slots, input logic [4:0] klimit,
                                    input int count);
        set_registers(slots, klimit);
        repeat (count)
            send_request(random_table_request());
    endtask

    // check codes of insert, lookup, close and alive short of full and overflow, at the reset settings
    task automatic test_id_checks();
        logic [63:0] ones;
        ones = '1;
        send_request(make_req(MODE_INSERT, 0, 0, 4'd1, ones, 1'b1, ones));
        send_request(make_req(MODE_INSERT, 0, 0, 4'd9, 64'd1, 1'b0, {$urandom, $urandom}));
        send_request(make_req(MODE_INSERT, 0, 0, 4'd0, 64'd5, 1'b1, 64'd7));
        send_request(make_req(MODE_INSERT, 0, 0, 4'd10, 64'd5, 1'b0, 64'd0));
        send_request(make_req(MODE_INSERT, ones[31:0], ones[31:0], 4'd15, ones, 1'b1, ones));
        send_request(make_req(MODE_INSERT, 0, 0, 4'd3, 64'd0, 1'b1, 64'd3));
        // slot 1 holds kind 1, slot 2 kind 9, both at generation 1
        send_request(make_req(MODE_LOOKUP, 1, 1, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_LOOKUP, 1, 1, 4'd0, 0, 1'b0, 0));
        send_request(make_req(MODE_LOOKUP, 0, 1, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_LOOKUP, 1, 0, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_LOOKUP, 33, 1, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_LOOKUP, ones[31:0], ones[31:0], 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_LOOKUP, 1, 2, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_LOOKUP, 3, 1, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_LOOKUP, 2, 1, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_ALIVE, 1, 1, 4'd0, 0, 1'b0, 0));
        send_request(make_req(MODE_ALIVE, 3, 1, 4'd0, 0, 1'b0, 0));
        send_request(make_req(MODE_ALIVE, 0, 1, 4'd0, 0, 1'b0, 0));
        send_request(make_req(MODE_CLOSE_KIND, 1, 1, 4'd2, 0, 1'b0, 0));
        send_request(make_req(MODE_CLOSE_KIND, 1, 1, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_CLOSE_KIND, 1, 1, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_CLOSE_KIND, 1, 2, 4'd1, 0, 1'b0, 0));
        send_request(make_req(MODE_CLOSE_STORED, 2, 1, 4'd0, 0, 1'b0, 0));
        send_request(make_req(MODE_SPARE_A, 1, 1, 4'd1, 64'd1, 1'b0, 0));
        send_request(make_req(MODE_SPARE_B, ones[31:0], ones[31:0], 4'hF, ones, 1'b1, ones));
    endtask

    // close by stored kind when the kind limit no longer covers the stored kind
    task automatic test_stored_kind_fallback();
        set_registers(6'd32, 5'd10);
        send_request(make_req(MODE_INSERT, 0, 0, 4'd9, {$urandom, $urandom | 32'd1}, 1'b1,
                              {$urandom, $urandom}));
        send_request(make_req(MODE_CLOSE_STORED, 0, 1, 4'd0, 0, 1'b0, 0));
        send_request(make_req(MODE_CLOSE_STORED, 40, 1, 4'd0, 0, 1'b0, 0));
        // stored 9 is out, kind 5 stands in and mismatches
        set_registers(6'd32, 5'd7);
        send_request(make_req(MODE_CLOSE_STORED, 1, tab_gen[0], 4'd0, 0, 1'b0, 0));
        // with the limit at 4 even kind 5 is refused
        set_registers(6'd32, 5'd4);
        send_request(make_req(MODE_CLOSE_STORED, 1, tab_gen[0], 4'd0, 0, 1'b0, 0));
        send_request(make_req(MODE_LOOKUP, 1, tab_gen[0], 4'd9, 0, 1'b0, 0));
        send_request(make_req(MODE_ALIVE, 1, tab_gen[0], 4'd9, 0, 1'b0, 0));
        set_registers(6'd32, 5'd10);
        send_request(make_req(MODE_CLOSE_STORED, 1, tab_gen[0], 4'd0, 0, 1'b0, 0));
    endtask

    task automatic test_register_settings();
        run_random_phase(6'd32, 5'd16, 50);
        run_random_phase(6'd1, 5'd2, 20);
        run_random_phase(6'd0, 5'd1, 15);
        run_random_phase(6'd7, 5'd5, 35);
        run_random_phase($urandom_range(2, 31), $urandom_range(2, 15), 30);
        run_random_phase(6'd32, 5'd10, 45);
    endtask

    task automatic test_full_rate();
        full_rate = 1'b1;
        run_random_phase(6'd20, 5'd10, 25);
        hold_requests();
        full_rate = 1'b0;
    endtask

    // fill every slot, run into full, then dispose twice and poke the empty table
    task automatic test_fill_then_dispose();
        set_registers(6'd32, 5'd16);
        repeat (SLOT_COUNT + 2)
            send_request(make_req(MODE_INSERT, 0, 0, $urandom_range(1, 15),
                                  {$urandom, $urandom | 32'd1}, $urandom_range(0, 1),
                                  {$urandom, $urandom}));
        send_request(make_req(MODE_DISPOSE, $urandom, $urandom, $urandom_range(0, 15),
                              {$urandom, $urandom}, 1'b1, {$urandom, $urandom}));
        send_request(make_req(MODE_DISPOSE, 0, 0, 4'd0, 0, 1'b0, 0));
        repeat (10)
            send_request(random_table_request());
    endtask

    initial begin
        table_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_id_checks();
        test_stored_kind_fallback();
        test_register_settings();
        test_full_rate();
        test_fill_then_dispose();

        wait_until_idle();
        repeat (16) @(posedge clk);
        $display("covered %0d requests and %0d results over %0d register settings,",
                 req_count, rsp_count, setting_count);
        $display("including %0d dispose events and the empty-table dispose", dispose_events);
        if (error_count == 0) begin
            $display("generational_handle_table_core test passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("generational_handle_table_core test failed");
        end
        $finish;
    end

endmodule
